FILE: rtl/core/ttnl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnl_pkg
// Shared constants, operation codes and sequencer states of the sorted
// timestamp table.
// ----------------------------------------------------------------------------
package ttnl_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int STAMP_BITS_DEF  = 48;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int CFG_BITS        = 11;
  localparam logic [CFG_BITS-1:0] LIMIT_RESET = 11'd1000;

  localparam logic [3:0] FN_PUSH   = 4'd0;
  localparam logic [3:0] FN_POP    = 4'd1;
  localparam logic [3:0] FN_RETIME = 4'd2;
  localparam logic [3:0] FN_SET    = 4'd3;
  localparam logic [3:0] FN_GET    = 4'd4;
  localparam logic [3:0] FN_PAST   = 4'd5;
  localparam logic [3:0] FN_FUTURE = 4'd6;
  localparam logic [3:0] FN_BOTH   = 4'd7;
  localparam logic [3:0] FN_NEWEST = 4'd8;
  localparam logic [3:0] FN_CLEAR  = 4'd9;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_USED = 2'd2;
  localparam logic [1:0] ST_DUP  = 2'd3;

  localparam logic [0:0] REG_MAX_ENTRIES = 1'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_CMP,
    S_POST,
    S_MV_RD,
    S_MV_WR,
    S_IN_RD,
    S_IN_WR,
    S_IN_PUT,
    S_NEW_RD,
    S_NEW_GET,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RT_OLD,
    RT_NEW,
    RT_INS
  } rt_step_t;

endpackage

FILE: rtl/core/timestamp_table_nearest_lookup_unit.sv
`timescale 1ns / 1ps
// Each word is paced by the entry memory port: a key scan reads the entries in
// order through S_SC_RD and S_SC_CMP, and every shift moves one entry through
// a read and a write state; a retime can take two scans, a removal, a rescan
// and an insertion. Throughput: one word at a time; a new word is taken once
// the previous result is in the output register. Reset (synchronous) empties
// the table and sets max_entries to 1000; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
// timestamp_table_nearest_lookup_unit
// Sorted timestamp table with exact and nearest lookup and a register port.
// ----------------------------------------------------------------------------
module timestamp_table_nearest_lookup_unit import ttnl_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int STAMP_BITS  = STAMP_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0]             func,
  input  logic [STAMP_BITS-1:0]  stamp,
  input  logic [STAMP_BITS-1:0]  new_stamp,
  input  logic [HANDLE_BITS-1:0] payload,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [HANDLE_BITS-1:0] out_payload,
  output logic [STAMP_BITS-1:0]  out_stamp,
  output logic [1:0]             status,
  output logic                   evicted,
  output logic [CW-1:0]          entry_count
);

  logic [CFG_BITS-1:0] max_entries;
  logic [CW-1:0]       limit;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_MAX_ENTRIES) ? {{(32-CFG_BITS){1'b0}}, max_entries} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2:2] == REG_MAX_ENTRIES)) begin
      max_entries <= pwdata[CFG_BITS-1:0];
    end
  end

  always_comb begin
    if (max_entries == '0) begin
      limit = CW'(1);
    end else if ({21'd0, max_entries} > 32'(DEPTH)) begin
      limit = CW'(DEPTH);
    end else begin
      limit = CW'({21'd0, max_entries});
    end
  end

  ttnl_core #(
    .DEPTH       (DEPTH),
    .STAMP_BITS  (STAMP_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .limit       (limit),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .stamp       (stamp),
    .new_stamp   (new_stamp),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .out_payload (out_payload),
    .out_stamp   (out_stamp),
    .status      (status),
    .evicted     (evicted),
    .entry_count (entry_count)
  );

endmodule

FILE: rtl/core/ttnl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnl_core
// Sequencer, entry memory and result register of the sorted timestamp table.
// ----------------------------------------------------------------------------
module ttnl_core import ttnl_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int STAMP_BITS  = STAMP_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CW-1:0]          limit,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0]             func,
  input  logic [STAMP_BITS-1:0]  stamp,
  input  logic [STAMP_BITS-1:0]  new_stamp,
  input  logic [HANDLE_BITS-1:0] payload,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [HANDLE_BITS-1:0] out_payload,
  output logic [STAMP_BITS-1:0]  out_stamp,
  output logic [1:0]             status,
  output logic                   evicted,
  output logic [CW-1:0]          entry_count
);

  localparam int EW = STAMP_BITS + HANDLE_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  state_t   state, state_next;
  rt_step_t rt, rt_next;
  logic [CW-1:0] count, count_next, idx, idx_next, pos, pos_next, posk, posk_next;
  logic [EW-1:0] cur, cur_next, prev, prev_next;
  logic [STAMP_BITS-1:0] tgt, tgt_next, ins_key, ins_key_next;
  logic [HANDLE_BITS-1:0] ins_pl, ins_pl_next;
  logic strict, strict_next;
  logic [3:0] f_func, f_func_next;
  logic [STAMP_BITS-1:0] f_k, f_k_next, f_nk, f_nk_next;
  logic [HANDLE_BITS-1:0] f_pl, f_pl_next;
  logic r_found, r_found_next, r_ev, r_ev_next;
  logic [EW-1:0] r_ent, r_ent_next;
  logic [1:0] r_status, r_status_next;
  logic load_out;

  logic [STAMP_BITS-1:0] rd_key, cur_key, prev_key, up, down;
  logic hit, below;

  assign rd_key   = rd_q[EW-1:HANDLE_BITS];
  assign cur_key  = cur[EW-1:HANDLE_BITS];
  assign prev_key = prev[EW-1:HANDLE_BITS];
  assign hit      = (pos < count) && (cur_key == tgt);
  assign below    = strict ? (rd_key <= tgt) : (rd_key < tgt);
  assign up       = cur_key - f_k;
  assign down     = f_k - prev_key;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rt       <= rt_next;
    idx      <= idx_next;
    pos      <= pos_next;
    posk     <= posk_next;
    cur      <= cur_next;
    prev     <= prev_next;
    tgt      <= tgt_next;
    strict   <= strict_next;
    ins_key  <= ins_key_next;
    ins_pl   <= ins_pl_next;
    f_func   <= f_func_next;
    f_k      <= f_k_next;
    f_nk     <= f_nk_next;
    f_pl     <= f_pl_next;
    r_found  <= r_found_next;
    r_ev     <= r_ev_next;
    r_ent    <= r_ent_next;
    r_status <= r_status_next;
    if (load_out) begin
      found       <= r_found;
      out_payload <= r_ent[HANDLE_BITS-1:0];
      out_stamp   <= r_ent[EW-1:HANDLE_BITS];
      status      <= r_status;
      evicted     <= r_ev;
      entry_count <= count;
    end
  end

  always_comb begin
    state_next    = state;
    rt_next       = rt;
    count_next    = count;
    idx_next      = idx;
    pos_next      = pos;
    posk_next     = posk;
    cur_next      = cur;
    prev_next     = prev;
    tgt_next      = tgt;
    strict_next   = strict;
    ins_key_next  = ins_key;
    ins_pl_next   = ins_pl;
    f_func_next   = f_func;
    f_k_next      = f_k;
    f_nk_next     = f_nk;
    f_pl_next     = f_pl;
    r_found_next  = r_found;
    r_ev_next     = r_ev;
    r_ent_next    = r_ent;
    r_status_next = r_status;
    we            = 1'b0;
    waddr         = idx[AW-1:0];
    wdata         = rd_q;
    raddr         = idx[AW-1:0];
    load_out      = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          f_func_next   = func;
          f_k_next      = stamp;
          f_nk_next     = new_stamp;
          f_pl_next     = payload;
          r_found_next  = 1'b0;
          r_ev_next     = 1'b0;
          r_ent_next    = '0;
          r_status_next = ST_OK;
          rt_next       = RT_OLD;
          idx_next      = '0;
          tgt_next      = stamp;
          strict_next   = (func == FN_PAST);
          state_next    = S_SC_RD;
          case (func)
            FN_PUSH: begin
              if (count >= limit) begin
                r_ev_next  = 1'b1;
                state_next = S_MV_RD;
              end
            end
            FN_POP, FN_RETIME, FN_SET, FN_GET, FN_PAST, FN_FUTURE, FN_BOTH: begin
            end
            FN_NEWEST: begin
              state_next = (count != '0) ? S_NEW_RD : S_DONE;
            end
            FN_CLEAR: begin
              count_next = '0;
              state_next = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SC_RD: begin
        if (idx >= count) begin
          pos_next   = idx;
          state_next = S_POST;
        end else begin
          state_next = S_SC_CMP;
        end
      end
      S_SC_CMP: begin
        if (below) begin
          prev_next  = rd_q;
          idx_next   = idx + 1'b1;
          state_next = S_SC_RD;
        end else begin
          pos_next   = idx;
          cur_next   = rd_q;
          state_next = S_POST;
        end
      end
      S_POST: begin
        state_next = S_DONE;
        case (f_func)
          FN_PUSH: begin
            if (hit) begin
              r_status_next = ST_DUP;
            end else if (count < DEPTH_C) begin
              ins_key_next = f_k;
              ins_pl_next  = f_pl;
              idx_next     = count;
              state_next   = S_IN_RD;
            end
          end
          FN_POP: begin
            if (hit) begin
              r_found_next = 1'b1;
              r_ent_next   = cur;
              idx_next     = pos;
              state_next   = S_MV_RD;
            end else begin
              r_status_next = ST_MISS;
            end
          end
          FN_RETIME: begin
            case (rt)
              RT_OLD: begin
                if (!hit) begin
                  r_status_next = ST_MISS;
                end else begin
                  posk_next   = pos;
                  ins_pl_next = cur[HANDLE_BITS-1:0];
                  rt_next     = RT_NEW;
                  idx_next    = '0;
                  tgt_next    = f_nk;
                  state_next  = S_SC_RD;
                end
              end
              RT_NEW: begin
                if (hit) begin
                  r_status_next = ST_USED;
                end else begin
                  rt_next    = RT_INS;
                  idx_next   = posk;
                  state_next = S_MV_RD;
                end
              end
              default: begin
                if (count < DEPTH_C) begin
                  ins_key_next = f_nk;
                  idx_next     = count;
                  state_next   = S_IN_RD;
                end
              end
            endcase
          end
          FN_SET: begin
            if (hit) begin
              we    = 1'b1;
              waddr = pos[AW-1:0];
              wdata = {f_k, f_pl};
            end else begin
              r_status_next = ST_MISS;
            end
          end
          FN_GET: begin
            if (hit) begin
              r_found_next = 1'b1;
              r_ent_next   = cur;
            end else begin
              r_status_next = ST_MISS;
            end
          end
          FN_PAST: begin
            if (pos != '0) begin
              r_found_next = 1'b1;
              r_ent_next   = prev;
            end
          end
          FN_FUTURE: begin
            if (pos < count) begin
              r_found_next = 1'b1;
              r_ent_next   = cur;
            end
          end
          FN_BOTH: begin
            if (count != '0) begin
              r_found_next = 1'b1;
              if (pos == '0) begin
                r_ent_next = cur;
              end else if (pos >= count) begin
                r_ent_next = prev;
              end else begin
                r_ent_next = (up > down) ? prev : cur;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_MV_RD: begin
        if ((idx + 1'b1) >= count) begin
          count_next = count - 1'b1;
          idx_next   = '0;
          tgt_next   = (f_func == FN_RETIME) ? f_nk : f_k;
          state_next = (f_func == FN_POP) ? S_DONE : S_SC_RD;
        end else begin
          raddr      = AW'(idx + 1'b1);
          state_next = S_MV_WR;
        end
      end
      S_MV_WR: begin
        we         = 1'b1;
        idx_next   = idx + 1'b1;
        state_next = S_MV_RD;
      end
      S_IN_RD: begin
        if (idx <= pos) begin
          state_next = S_IN_PUT;
        end else begin
          raddr      = AW'(idx - 1'b1);
          state_next = S_IN_WR;
        end
      end
      S_IN_WR: begin
        we         = 1'b1;
        idx_next   = idx - 1'b1;
        state_next = S_IN_RD;
      end
      S_IN_PUT: begin
        we         = 1'b1;
        waddr      = pos[AW-1:0];
        wdata      = {ins_key, ins_pl};
        count_next = count + 1'b1;
        state_next = S_DONE;
      end
      S_NEW_RD: begin
        raddr      = AW'(count - 1'b1);
        state_next = S_NEW_GET;
      end
      S_NEW_GET: begin
        r_found_next = 1'b1;
        r_ent_next   = rd_q;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
